[rtl/ptwl_pkg.sv]
// Package for the page table walk lookup block: payload structs, walker states,
// fault codes, descriptor type codes and configuration register indexes.
// No dependencies; page_table_walk_lookup imports it.
package ptwl_pkg;

	localparam int VA_W    = 48;
	localparam int ENTRY_W = 64;
	localparam int SIDX_W  = 12;
	localparam int SIZE_W  = 6;
	localparam int FAULT_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int LEVELS_W   = 3;
	localparam int SPACE_W    = 6;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROOT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE  = 2'd2;

	localparam logic [1:0] DESC_BLOCK = 2'b01;
	localparam logic [1:0] DESC_TABLE = 2'b11;

	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE       = 3'd0,
		FAULT_SPACE      = 3'd1,
		FAULT_INVALID    = 3'd2,
		FAULT_LAST_TABLE = 3'd3,
		FAULT_STORE      = 3'd4
	} fault_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               operation;
		logic [VA_W-1:0]    vaddr;
		logic [SIDX_W-1:0]  store_index;
		logic [ENTRY_W-1:0] store_data;
	} ptwl_in_t;

	typedef struct packed {
		logic               found;
		logic [VA_W-1:0]    paddr;
		logic [SIZE_W-1:0]  page_shift;
		logic [ENTRY_W-1:0] leaf_entry;
		logic [FAULT_W-1:0] fault_kind;
	} ptwl_out_t;

endpackage

[rtl/ptwl_ram.sv]
// Generic single-clock RAM: one write port and one read port with registered read data.
// No dependencies.
module ptwl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/page_table_walk_lookup.sv]
// Top level of the page table walk lookup: descriptor store, walker state machine,
// output register and configuration registers. Depends on ptwl_pkg and ptwl_ram.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid / in_stall   | in_data (ptwl_in_t)
//   out     | output    | out_valid / out_stall | out_data (ptwl_out_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A write item with an index inside the store is written as it is taken. A lookup is taken
// and then walks each level by addressing the store, then decoding the descriptor; the single
// read port of the descriptor store sets this order, since each level depends on the last.
// After reset the store is zeroed one word per cycle with in_stall high. A finished result
// sits in the output register while the next item is taken; the walker holds its last step
// when the output register is still full.
module page_table_walk_lookup
	import ptwl_pkg::*;
#(
	parameter int GRANULE_BITS = 12,
	parameter int STORE_DEPTH  = 4096,
	parameter int PA_BITS      = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ptwl_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ptwl_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW     = $clog2(STORE_DEPTH);
	localparam int IW     = GRANULE_BITS - 3;
	localparam int WORD_W = VA_W - 2;
	localparam logic [ENTRY_W-1:0] PA_MASK   = ENTRY_W'((65'd1 << PA_BITS) - 65'd1);
	localparam logic [ENTRY_W-1:0] GRAN_MASK = ENTRY_W'((65'd1 << GRANULE_BITS) - 65'd1);
	localparam logic [ENTRY_W-1:0] ALL_ONES  = '1;
	localparam logic [VA_W-1:0]    VA_ONES   = '1;

	function automatic logic [SIZE_W-1:0] range_of(input logic [1:0] lvl);
		range_of = SIZE_W'(GRANULE_BITS + int'(lvl) * (GRANULE_BITS - 3));
	endfunction

	// Configuration registers.
	logic [VA_W-1:0]     root_q;
	logic [LEVELS_W-1:0] levels_q;
	logic [SPACE_W-1:0]  space_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q   <= '0;
			levels_q <= LEVELS_W'(4);
			space_q  <= SPACE_W'(48);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROOT:   root_q   <= cfg_data;
				CFG_LEVELS: levels_q <= cfg_data[LEVELS_W-1:0];
				CFG_SPACE:  space_q  <= cfg_data[SPACE_W-1:0];
				default:    ;
			endcase
		end
	end

	// Walker state and working registers.
	state_t             state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [VA_W-1:0]    va_q;
	logic [VA_W-1:0]    node_q, node_d;
	logic [1:0]         level_q, level_d;
	logic [FAULT_W-1:0] fin_fault_q, fin_fault_d;
	logic               fin_load;
	logic               descend;

	logic               in_accept;
	logic               slot_free;
	logic               load_out;
	ptwl_out_t          out_d;
	ptwl_out_t          out_q;
	logic               out_valid_q;

	// Descriptor store ports.
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	// Address decode for the current level.
	logic [IW-1:0]      idx;
	logic [WORD_W-1:0]  word;
	logic               word_oob;
	logic [SIZE_W-1:0]  rng;
	logic [ENTRY_W-1:0] low_mask;
	logic [1:0]         start_level;
	logic               space_fault;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	assign rng      = range_of(level_q);
	assign idx      = IW'({{(ENTRY_W-VA_W){1'b0}}, va_q} >> rng);
	assign word     = {1'b0, node_q[VA_W-1:3]} + WORD_W'(idx);
	assign word_oob = (word >= WORD_W'(STORE_DEPTH));
	assign low_mask = ~(ALL_ONES << rng);

	always_comb begin
		if (levels_q == '0) begin
			start_level = 2'd0;
		end else if (levels_q > LEVELS_W'(4)) begin
			start_level = 2'd3;
		end else begin
			start_level = 2'(levels_q - LEVELS_W'(1));
		end
	end

	assign space_fault = (space_q < SPACE_W'(48)) &&
		((in_data.vaddr & (VA_ONES << space_q)) != '0);

	// Store write port: the clearing sweep after reset, then write items.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = in_accept && (in_data.operation == OP_WRITE) &&
				(32'(in_data.store_index) < STORE_DEPTH);
			ram_waddr = AW'(in_data.store_index);
			ram_wdata = in_data.store_data;
		end
	end

	ptwl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (word[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_re      = 1'b0;
		load_out    = 1'b0;
		out_d       = '0;
		fin_load    = 1'b0;
		fin_fault_d = FAULT_NONE;
		descend     = 1'b0;
		node_d      = VA_W'(ram_rdata & PA_MASK & ~GRAN_MASK);
		level_d     = level_q - 2'd1;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_accept) begin
					if (in_data.operation == OP_WRITE) begin
						fin_load    = 1'b1;
						fin_fault_d = FAULT_NONE;
						state_d     = ST_FINISH;
					end else if (space_fault) begin
						fin_load    = 1'b1;
						fin_fault_d = FAULT_SPACE;
						state_d     = ST_FINISH;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (word_oob) begin
					fin_load    = 1'b1;
					fin_fault_d = FAULT_STORE;
					state_d     = ST_FINISH;
				end else begin
					ram_re  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (!ram_rdata[0]) begin
					out_d.fault_kind = FAULT_INVALID;
				end else if ((level_q == 2'd0 && ram_rdata[1:0] == DESC_TABLE) ||
					(level_q != 2'd0 && ram_rdata[1:0] == DESC_BLOCK)) begin
					out_d.found      = 1'b1;
					out_d.paddr      = VA_W'((ram_rdata & PA_MASK & ~low_mask) |
						({{(ENTRY_W-VA_W){1'b0}}, va_q} & low_mask));
					out_d.page_shift = rng;
					out_d.leaf_entry = ram_rdata;
					out_d.fault_kind = FAULT_NONE;
				end else if (level_q == 2'd0) begin
					out_d.fault_kind = FAULT_LAST_TABLE;
				end else begin
					descend = 1'b1;
				end
				if (descend) begin
					state_d = ST_READ;
				end else if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FINISH: begin
				out_d.fault_kind = fin_fault_q;
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			va_q    <= in_data.vaddr;
			node_q  <= root_q;
			level_q <= start_level;
		end else if (descend) begin
			node_q  <= node_d;
			level_q <= level_d;
		end
		if (fin_load) begin
			fin_fault_q <= fin_fault_d;
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	// Output register; a new result enters only when the previous one has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_store_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE || state_q == ST_CLEAR))
		else $error("descriptor store written while a walk is in flight");

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_EVAL))
		else $error("descriptor decoded without a preceding store read");

	a_descend_level: assert property (@(posedge clk) disable iff (!arst_n)
		descend |=> (level_q == $past(level_q) - 2'd1) && (state_q == ST_READ))
		else $error("table descent did not step down one level");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("result loaded over one not yet transferred");
`endif

endmodule
